@@ rtl/core/wsi_pkg.sv @@
// Shared types and constants for the wrapped segment intersection block.
// Used by every module under rtl/core; depends on nothing else.
package wsi_pkg;

    localparam int FRAC_BITS = 28;
    localparam int IN_W      = 32;
    localparam int LIM_W     = 31;
    localparam int Q_W       = 32;
    localparam int PRE_W     = Q_W - FRAC_BITS;
    localparam int LON_W     = IN_W + 2;
    localparam int DLT_W     = LON_W + 1;
    localparam int PROD_W    = 2 * DLT_W;
    localparam int NUM_W     = PROD_W + 1;
    localparam int MAG_W     = NUM_W;
    localparam int RAT_W     = Q_W + 2;
    localparam int TP_W      = Q_W + DLT_W;
    localparam int SUM_W     = TP_W - FRAC_BITS + 1;
    localparam int DIV_STAGES = Q_W;

    localparam logic [63:0] PI60 = 64'h3243F6A8885A308D;
    localparam logic [63:0] PI_Q64 =
        (PI60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
    localparam logic [63:0] TWO_PI_Q64 =
        ((PI60 << 1) + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
    localparam logic signed [LON_W-1:0] PI_L     = PI_Q64[LON_W-1:0];
    localparam logic signed [LON_W-1:0] TWO_PI_L = TWO_PI_Q64[LON_W-1:0];

    localparam logic signed [LIM_W-1:0] LOW_RESET  = '0;
    localparam logic signed [LIM_W-1:0] HIGH_RESET = LIM_W'(1 << FRAC_BITS);

    typedef enum logic {
        REG_LOW  = 1'b0,
        REG_HIGH = 1'b1
    } reg_idx_t;

    // Deltas and offsets after longitude normalisation.
    typedef struct packed {
        logic signed [DLT_W-1:0] dx1;
        logic signed [DLT_W-1:0] dx2;
        logic signed [DLT_W-1:0] dym;
        logic signed [DLT_W-1:0] dyb;
        logic signed [DLT_W-1:0] x;
        logic signed [DLT_W-1:0] y;
        logic signed [IN_W-1:0]  lat;
        logic signed [LON_W-1:0] lon;
    } norm_t;

    // What the crossing stage needs from the start of the move.
    typedef struct packed {
        logic signed [IN_W-1:0]  lat;
        logic signed [LON_W-1:0] lon;
        logic signed [DLT_W-1:0] dym;
        logic signed [DLT_W-1:0] dx1;
    } side_t;

    typedef struct packed {
        logic             neg;
        logic             ok;
        logic [MAG_W-1:0] num;
        logic [MAG_W-1:0] den;
    } div_in_t;

    typedef struct packed {
        logic           neg;
        logic           ok;
        logic           inexact;
        logic [Q_W-1:0] q;
    } div_out_t;

endpackage

@@ rtl/core/wsi_norm.sv @@
// Longitude wrap normalisation and delta formation, three register stages.
// Depends on wsi_pkg.
module wsi_norm (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_vld,
    input  logic signed [wsi_pkg::IN_W-1:0]   move_start_lat,
    input  logic signed [wsi_pkg::IN_W-1:0]   move_start_lon,
    input  logic signed [wsi_pkg::IN_W-1:0]   move_end_lat,
    input  logic signed [wsi_pkg::IN_W-1:0]   move_end_lon,
    input  logic signed [wsi_pkg::IN_W-1:0]   barrier_a_lat,
    input  logic signed [wsi_pkg::IN_W-1:0]   barrier_a_lon,
    input  logic signed [wsi_pkg::IN_W-1:0]   barrier_b_lat,
    input  logic signed [wsi_pkg::IN_W-1:0]   barrier_b_lon,
    output logic                              out_vld,
    output wsi_pkg::norm_t                    out_norm
);

    function automatic logic signed [wsi_pkg::LON_W-1:0] wrap_lon(
        input logic signed [wsi_pkg::IN_W-1:0] v
    );
        logic signed [wsi_pkg::LON_W-1:0] e;
        begin
            e = wsi_pkg::LON_W'(v);
            if (v < 0)
                e = e + wsi_pkg::TWO_PI_L;
            return e;
        end
    endfunction

    logic [2:0] vld_reg;

    logic signed [wsi_pkg::IN_W-1:0]  a_slat_reg, a_elat_reg, a_alat_reg, a_blat_reg;
    logic signed [wsi_pkg::LON_W-1:0] a_slon_reg, a_elon_reg, a_alon_reg, a_blon_reg;
    logic signed [wsi_pkg::LON_W-1:0] a_slon_next, a_elon_next, a_alon_next, a_blon_next;
    logic signed [wsi_pkg::LON_W-1:0] md, bd;

    logic signed [wsi_pkg::IN_W-1:0]  b_slat_reg, b_elat_reg, b_alat_reg, b_blat_reg;
    logic signed [wsi_pkg::LON_W-1:0] b_slon_reg, b_elon_reg, b_alon_reg, b_blon_reg;
    logic signed [wsi_pkg::LON_W-1:0] b_slon_next, b_elon_next, b_alon_next, b_blon_next;
    logic signed [wsi_pkg::LON_W-1:0] xd;

    wsi_pkg::norm_t norm_reg, norm_next;

    // Stage A: lift negative longitudes, then unwrap each segment on its own.
    always_comb
    begin
        a_slon_next = wrap_lon(move_start_lon);
        a_elon_next = wrap_lon(move_end_lon);
        a_alon_next = wrap_lon(barrier_a_lon);
        a_blon_next = wrap_lon(barrier_b_lon);
        md = a_slon_next - a_elon_next;
        bd = a_alon_next - a_blon_next;
        if (md > wsi_pkg::PI_L)
            a_slon_next = a_slon_next - wsi_pkg::TWO_PI_L;
        else if (md < -wsi_pkg::PI_L)
            a_elon_next = a_elon_next - wsi_pkg::TWO_PI_L;
        if (bd > wsi_pkg::PI_L)
            a_alon_next = a_alon_next - wsi_pkg::TWO_PI_L;
        else if (bd < -wsi_pkg::PI_L)
            a_blon_next = a_blon_next - wsi_pkg::TWO_PI_L;
    end

    // Stage B: bring the two segments onto the same side of the seam.
    always_comb
    begin
        b_slon_next = a_slon_reg;
        b_elon_next = a_elon_reg;
        b_alon_next = a_alon_reg;
        b_blon_next = a_blon_reg;
        xd = a_slon_reg - a_alon_reg;
        if (xd > wsi_pkg::PI_L)
        begin
            b_slon_next = a_slon_reg - wsi_pkg::TWO_PI_L;
            b_elon_next = a_elon_reg - wsi_pkg::TWO_PI_L;
        end
        else if (xd < -wsi_pkg::PI_L)
        begin
            b_alon_next = a_alon_reg - wsi_pkg::TWO_PI_L;
            b_blon_next = a_blon_reg - wsi_pkg::TWO_PI_L;
        end
    end

    // Stage C: deltas and offsets.
    always_comb
    begin
        norm_next.dx1 = wsi_pkg::DLT_W'(b_elon_reg) - wsi_pkg::DLT_W'(b_slon_reg);
        norm_next.dx2 = wsi_pkg::DLT_W'(b_blon_reg) - wsi_pkg::DLT_W'(b_alon_reg);
        norm_next.dym = wsi_pkg::DLT_W'(b_elat_reg) - wsi_pkg::DLT_W'(b_slat_reg);
        norm_next.dyb = wsi_pkg::DLT_W'(b_blat_reg) - wsi_pkg::DLT_W'(b_alat_reg);
        norm_next.x   = wsi_pkg::DLT_W'(b_slon_reg) - wsi_pkg::DLT_W'(b_alon_reg);
        norm_next.y   = wsi_pkg::DLT_W'(b_slat_reg) - wsi_pkg::DLT_W'(b_alat_reg);
        norm_next.lat = b_slat_reg;
        norm_next.lon = b_slon_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[1:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        a_slat_reg <= move_start_lat;
        a_elat_reg <= move_end_lat;
        a_alat_reg <= barrier_a_lat;
        a_blat_reg <= barrier_b_lat;
        a_slon_reg <= a_slon_next;
        a_elon_reg <= a_elon_next;
        a_alon_reg <= a_alon_next;
        a_blon_reg <= a_blon_next;
        b_slat_reg <= a_slat_reg;
        b_elat_reg <= a_elat_reg;
        b_alat_reg <= a_alat_reg;
        b_blat_reg <= a_blat_reg;
        b_slon_reg <= b_slon_next;
        b_elon_reg <= b_elon_next;
        b_alon_reg <= b_alon_next;
        b_blon_reg <= b_blon_next;
        norm_reg   <= norm_next;
    end

    assign out_vld  = vld_reg[2];
    assign out_norm = norm_reg;

endmodule

@@ rtl/core/wsi_solve.sv @@
// Cross products, determinant and numerators, then magnitudes for the dividers.
// Three register stages; depends on wsi_pkg.
module wsi_solve (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_vld,
    input  wsi_pkg::norm_t   in_norm,
    output logic             out_vld,
    output wsi_pkg::div_in_t out_t,
    output wsi_pkg::div_in_t out_s,
    output wsi_pkg::side_t   out_side
);

    function automatic wsi_pkg::div_in_t prep(
        input logic signed [wsi_pkg::NUM_W-1:0] num,
        input logic signed [wsi_pkg::NUM_W-1:0] den
    );
        wsi_pkg::div_in_t r;
        begin
            r.num = num[wsi_pkg::NUM_W-1] ? wsi_pkg::MAG_W'(-num) : wsi_pkg::MAG_W'(num);
            r.den = den[wsi_pkg::NUM_W-1] ? wsi_pkg::MAG_W'(-den) : wsi_pkg::MAG_W'(den);
            r.neg = (num[wsi_pkg::NUM_W-1] != den[wsi_pkg::NUM_W-1]) && (num != '0);
            // The quotient has to fit the ratio word, otherwise it is a miss anyway.
            r.ok  = (den != '0) &&
                    ({{wsi_pkg::PRE_W{1'b0}}, r.num} < {r.den, {wsi_pkg::PRE_W{1'b0}}});
            return r;
        end
    endfunction

    logic [2:0] vld_reg;
    logic signed [wsi_pkg::PROD_W-1:0] p_d1_reg, p_d2_reg, p_t1_reg, p_t2_reg;
    logic signed [wsi_pkg::PROD_W-1:0] p_s1_reg, p_s2_reg;
    logic signed [wsi_pkg::NUM_W-1:0]  det_reg, nt_reg, ns_reg;
    wsi_pkg::side_t   side0_reg, side1_reg, side2_reg, side_next;
    wsi_pkg::div_in_t t_reg, s_reg;

    always_comb
    begin
        side_next.lat = in_norm.lat;
        side_next.lon = in_norm.lon;
        side_next.dym = in_norm.dym;
        side_next.dx1 = in_norm.dx1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[1:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        p_d1_reg  <= in_norm.dyb * in_norm.dx1;
        p_d2_reg  <= in_norm.dx2 * in_norm.dym;
        p_t1_reg  <= in_norm.dx2 * in_norm.y;
        p_t2_reg  <= in_norm.dyb * in_norm.x;
        p_s1_reg  <= in_norm.dx1 * in_norm.y;
        p_s2_reg  <= in_norm.dym * in_norm.x;
        side0_reg <= side_next;

        det_reg   <= wsi_pkg::NUM_W'(p_d1_reg) - wsi_pkg::NUM_W'(p_d2_reg);
        nt_reg    <= wsi_pkg::NUM_W'(p_t1_reg) - wsi_pkg::NUM_W'(p_t2_reg);
        ns_reg    <= wsi_pkg::NUM_W'(p_s1_reg) - wsi_pkg::NUM_W'(p_s2_reg);
        side1_reg <= side0_reg;

        t_reg     <= prep(nt_reg, det_reg);
        s_reg     <= prep(ns_reg, det_reg);
        side2_reg <= side1_reg;
    end

    assign out_vld  = vld_reg[2];
    assign out_t    = t_reg;
    assign out_s    = s_reg;
    assign out_side = side2_reg;

endmodule

@@ rtl/core/wsi_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Gives floor(num * 2^FRAC_BITS / den) on magnitudes; depends on wsi_pkg.
module wsi_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_vld,
    input  wsi_pkg::div_in_t  in_op,
    output logic              out_vld,
    output wsi_pkg::div_out_t out_res
);

    localparam int N = wsi_pkg::DIV_STAGES;
    localparam int M = wsi_pkg::MAG_W;

    logic [N-1:0]             vld_reg;
    logic [M-1:0]             rem_reg [N];
    logic [M-1:0]             den_reg [N];
    logic [wsi_pkg::Q_W-1:0]  qn_reg  [N];
    logic [N-1:0]             neg_reg;
    logic [N-1:0]             ok_reg;

    for (genvar k = 0; k < N; k++)
    begin : g_step
        logic [M-1:0]            rem_in, den_in;
        logic [wsi_pkg::Q_W-1:0] qn_in;
        logic                    neg_in, ok_in, vld_in;
        logic [M+1:0]            diff;
        logic                    ge;

        if (k == 0)
        begin : g_first
            // The low numerator bits and the fraction zeros ride in the quotient word.
            assign rem_in = M'(in_op.num >> wsi_pkg::PRE_W);
            assign qn_in  = {in_op.num[wsi_pkg::PRE_W-1:0], {wsi_pkg::FRAC_BITS{1'b0}}};
            assign den_in = in_op.den;
            assign neg_in = in_op.neg;
            assign ok_in  = in_op.ok;
            assign vld_in = in_vld;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign qn_in  = qn_reg[k-1];
            assign den_in = den_reg[k-1];
            assign neg_in = neg_reg[k-1];
            assign ok_in  = ok_reg[k-1];
            assign vld_in = vld_reg[k-1];
        end

        assign diff = {1'b0, rem_in, qn_in[wsi_pkg::Q_W-1]} - {2'b00, den_in};
        assign ge   = !diff[M+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else
                vld_reg[k] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= ge ? diff[M-1:0] : {rem_in[M-2:0], qn_in[wsi_pkg::Q_W-1]};
            qn_reg[k]  <= {qn_in[wsi_pkg::Q_W-2:0], ge};
            den_reg[k] <= den_in;
            neg_reg[k] <= neg_in;
            ok_reg[k]  <= ok_in;
        end
    end

    assign out_vld         = vld_reg[N-1];
    assign out_res.q       = qn_reg[N-1];
    assign out_res.inexact = (rem_reg[N-1] != '0);
    assign out_res.neg     = neg_reg[N-1];
    assign out_res.ok      = ok_reg[N-1];

endmodule

@@ rtl/core/wsi_back.sv @@
// Ratio sign and limit test, crossing point products, saturation and result beat.
// Three register stages; depends on wsi_pkg.
module wsi_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_vld,
    input  wsi_pkg::div_out_t                   in_t,
    input  wsi_pkg::div_out_t                   in_s,
    input  wsi_pkg::side_t                      in_side,
    input  logic signed [wsi_pkg::LIM_W-1:0]    low_limit,
    input  logic signed [wsi_pkg::LIM_W-1:0]    high_limit,
    output logic                                done,
    output logic                                hit,
    output logic signed [wsi_pkg::Q_W-1:0]      move_ratio,
    output logic signed [wsi_pkg::IN_W-1:0]     cross_lat,
    output logic signed [wsi_pkg::IN_W-1:0]     cross_lon
);

    localparam logic signed [wsi_pkg::SUM_W-1:0] SAT_MAX =
        wsi_pkg::SUM_W'({1'b0, {(wsi_pkg::IN_W-1){1'b1}}});
    localparam logic signed [wsi_pkg::SUM_W-1:0] SAT_MIN =
        -wsi_pkg::SUM_W'({1'b0, {(wsi_pkg::IN_W-1){1'b1}}}) - 1'b1;

    function automatic logic signed [wsi_pkg::RAT_W-1:0] ratio(
        input wsi_pkg::div_out_t r
    );
        logic signed [wsi_pkg::RAT_W-1:0] q;
        begin
            q = wsi_pkg::RAT_W'({1'b0, r.q});
            // A negative inexact quotient rounds down, one step further from zero.
            if (r.neg)
                q = -q - wsi_pkg::RAT_W'(r.inexact);
            return q;
        end
    endfunction

    function automatic logic pass(
        input wsi_pkg::div_out_t                r,
        input logic signed [wsi_pkg::LIM_W-1:0] lo,
        input logic signed [wsi_pkg::LIM_W-1:0] hi
    );
        logic signed [wsi_pkg::RAT_W-1:0] v, l, h;
        begin
            v = ratio(r);
            l = wsi_pkg::RAT_W'(lo);
            h = wsi_pkg::RAT_W'(hi);
            // An inexact quotient sitting on the upper limit is really above it.
            return r.ok && (v >= l) && (v <= h) && !((v == h) && r.inexact);
        end
    endfunction

    function automatic logic signed [wsi_pkg::IN_W-1:0] sat(
        input logic signed [wsi_pkg::SUM_W-1:0] v
    );
        begin
            if (v > SAT_MAX)
                return SAT_MAX[wsi_pkg::IN_W-1:0];
            else if (v < SAT_MIN)
                return SAT_MIN[wsi_pkg::IN_W-1:0];
            else
                return v[wsi_pkg::IN_W-1:0];
        end
    endfunction

    logic [2:0] vld_reg;
    logic       g_hit_reg, m_hit_reg;
    logic signed [wsi_pkg::RAT_W-1:0] t_full;
    logic signed [wsi_pkg::Q_W-1:0]   g_t_reg, m_t_reg;
    wsi_pkg::side_t                   g_side_reg;
    logic signed [wsi_pkg::IN_W-1:0]  m_lat_reg;
    logic signed [wsi_pkg::LON_W-1:0] m_lon_reg;
    logic signed [wsi_pkg::TP_W-1:0]  m_plat_reg, m_plon_reg;
    logic signed [wsi_pkg::SUM_W-1:0] sum_lat, sum_lon;

    logic                             hit_reg;
    logic signed [wsi_pkg::Q_W-1:0]   ratio_reg;
    logic signed [wsi_pkg::IN_W-1:0]  lat_reg, lon_reg;

    assign t_full = ratio(in_t);

    assign sum_lat = wsi_pkg::SUM_W'(m_lat_reg) +
                     wsi_pkg::SUM_W'(m_plat_reg >>> wsi_pkg::FRAC_BITS);
    assign sum_lon = wsi_pkg::SUM_W'(m_lon_reg) +
                     wsi_pkg::SUM_W'(m_plon_reg >>> wsi_pkg::FRAC_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[1:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        g_hit_reg  <= pass(in_t, low_limit, high_limit) && pass(in_s, low_limit, high_limit);
        g_t_reg    <= t_full[wsi_pkg::Q_W-1:0];
        g_side_reg <= in_side;

        m_hit_reg  <= g_hit_reg;
        m_t_reg    <= g_t_reg;
        m_lat_reg  <= g_side_reg.lat;
        m_lon_reg  <= g_side_reg.lon;
        m_plat_reg <= g_t_reg * g_side_reg.dym;
        m_plon_reg <= g_t_reg * g_side_reg.dx1;

        hit_reg    <= m_hit_reg;
        ratio_reg  <= m_hit_reg ? m_t_reg : '0;
        lat_reg    <= m_hit_reg ? sat(sum_lat) : '0;
        lon_reg    <= m_hit_reg ? sat(sum_lon) : '0;
    end

    assign done       = vld_reg[2];
    assign hit        = hit_reg;
    assign move_ratio = ratio_reg;
    assign cross_lat  = lat_reg;
    assign cross_lon  = lon_reg;

endmodule

@@ rtl/core/wrapped_segment_intersection.sv @@
// Top level of the wrapped segment intersection block: limit registers,
// pipeline wiring and side delay line. Depends on wsi_pkg, wsi_norm,
// wsi_solve, wsi_div and wsi_back.
//
// Usage: drive the eight segment coordinates (signed Q4.28 radians) and
// raise start for one cycle per item; an item is taken on each edge where
// start is high and busy is low. busy stays low, so a new item may be
// started in every clock cycle.
// Each item gives one result beat: done is high for one cycle with hit,
// move_ratio, cross_lat and cross_lon valid. On a miss the three values
// read zero. The pipeline is the 32-step divider, plus nine stages for
// normalisation, products and the crossing point.
// The receiver cannot hold results back; every beat must be captured when
// done is high.
// The ratio limits sit on an APB port: low limit at address 0, high limit at
// address 4, both 31-bit signed Q3.28. Write them only while no item is in
// flight. Reset clears all pipeline valid bits and loads the limits with
// 0.0 and 1.0.
module wrapped_segment_intersection (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [wsi_pkg::IN_W-1:0]   move_start_lat,
    input  logic signed [wsi_pkg::IN_W-1:0]   move_start_lon,
    input  logic signed [wsi_pkg::IN_W-1:0]   move_end_lat,
    input  logic signed [wsi_pkg::IN_W-1:0]   move_end_lon,
    input  logic signed [wsi_pkg::IN_W-1:0]   barrier_a_lat,
    input  logic signed [wsi_pkg::IN_W-1:0]   barrier_a_lon,
    input  logic signed [wsi_pkg::IN_W-1:0]   barrier_b_lat,
    input  logic signed [wsi_pkg::IN_W-1:0]   barrier_b_lon,
    output logic                              done,
    output logic                              hit,
    output logic signed [wsi_pkg::Q_W-1:0]    move_ratio,
    output logic signed [wsi_pkg::IN_W-1:0]   cross_lat,
    output logic signed [wsi_pkg::IN_W-1:0]   cross_lon
);

    logic signed [wsi_pkg::LIM_W-1:0] low_reg, high_reg;
    logic                             wr_en;
    wsi_pkg::reg_idx_t                wr_idx;

    logic              accept;
    logic              norm_vld, solve_vld, div_t_vld, div_s_vld;
    wsi_pkg::norm_t    norm;
    wsi_pkg::div_in_t  dt_in, ds_in;
    wsi_pkg::div_out_t dt_out, ds_out;
    wsi_pkg::side_t    side_in;
    wsi_pkg::side_t    side_dly_reg [wsi_pkg::DIV_STAGES];

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign wr_en  = psel && penable && pwrite && pready;
    assign wr_idx = wsi_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= wsi_pkg::LOW_RESET;
            high_reg <= wsi_pkg::HIGH_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_idx)
                wsi_pkg::REG_LOW:  low_reg  <= pwdata[wsi_pkg::LIM_W-1:0];
                wsi_pkg::REG_HIGH: high_reg <= pwdata[wsi_pkg::LIM_W-1:0];
                default:           low_reg  <= low_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (wr_idx)
            wsi_pkg::REG_LOW:  prdata = 32'(low_reg);
            wsi_pkg::REG_HIGH: prdata = 32'(high_reg);
            default:           prdata = '0;
        endcase
    end

    wsi_norm u_norm (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_vld         (accept),
        .move_start_lat (move_start_lat),
        .move_start_lon (move_start_lon),
        .move_end_lat   (move_end_lat),
        .move_end_lon   (move_end_lon),
        .barrier_a_lat  (barrier_a_lat),
        .barrier_a_lon  (barrier_a_lon),
        .barrier_b_lat  (barrier_b_lat),
        .barrier_b_lon  (barrier_b_lon),
        .out_vld        (norm_vld),
        .out_norm       (norm)
    );

    wsi_solve u_solve (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (norm_vld),
        .in_norm  (norm),
        .out_vld  (solve_vld),
        .out_t    (dt_in),
        .out_s    (ds_in),
        .out_side (side_in)
    );

    wsi_div u_div_t (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (solve_vld),
        .in_op   (dt_in),
        .out_vld (div_t_vld),
        .out_res (dt_out)
    );

    wsi_div u_div_s (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (solve_vld),
        .in_op   (ds_in),
        .out_vld (div_s_vld),
        .out_res (ds_out)
    );

    // The start point and move deltas wait alongside the dividers.
    always_ff @(posedge clk)
    begin
        side_dly_reg[0] <= side_in;
        for (int i = 1; i < wsi_pkg::DIV_STAGES; i++)
            side_dly_reg[i] <= side_dly_reg[i-1];
    end

    wsi_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_vld     (div_t_vld && div_s_vld),
        .in_t       (dt_out),
        .in_s       (ds_out),
        .in_side    (side_dly_reg[wsi_pkg::DIV_STAGES-1]),
        .low_limit  (low_reg),
        .high_limit (high_reg),
        .done       (done),
        .hit        (hit),
        .move_ratio (move_ratio),
        .cross_lat  (cross_lat),
        .cross_lon  (cross_lon)
    );

endmodule

@@ verif/wrapped_segment_intersection_tb.sv @@
// Self-checking testbench for wrapped_segment_intersection: directed table then random segment pairs.
// Depends on wsi_pkg and the wrapped_segment_intersection RTL; predicts each result in wide integers.
module wrapped_segment_intersection_tb;

    localparam longint ONE_Q = 64'sd1 << wsi_pkg::FRAC_BITS;
    localparam longint PI_V = wsi_pkg::PI_Q64;
    localparam longint TWO_PI_V = wsi_pkg::TWO_PI_Q64;
    localparam int LATENCY = 41;

    typedef struct {
        logic signed [31:0] c [8];
    } seg_pair_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] ratio;
        logic signed [31:0] lat;
        logic signed [31:0] lon;
    } crossing_t;

    typedef struct {
        logic signed [31:0] c [8];
        logic               typed;
        crossing_t          res;
    } table_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic start = 1'b0;
    logic busy;
    logic signed [31:0] coord [8];
    logic done, hit;
    logic signed [31:0] move_ratio, cross_lat, cross_lon;

    longint low_lim = 0;
    longint high_lim = ONE_Q;
    crossing_t crossing_q [$];
    int errors = 0;
    int beats_seen = 0;
    int hits_seen = 0;
    int send_gap_pct = 0;

    initial for (int i = 0; i < 8; i++) coord[i] = '0;

    wrapped_segment_intersection dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy),
        .move_start_lat(coord[0]), .move_start_lon(coord[1]),
        .move_end_lat(coord[2]), .move_end_lon(coord[3]),
        .barrier_a_lat(coord[4]), .barrier_a_lon(coord[5]),
        .barrier_b_lat(coord[6]), .barrier_b_lon(coord[7]),
        .done(done), .hit(hit), .move_ratio(move_ratio),
        .cross_lat(cross_lat), .cross_lon(cross_lon)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #50_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Floor of num * 2^FRAC_BITS / den, with the in-limit test on the exact quotient.
    function automatic logic ratio_ok(logic signed [127:0] num, logic signed [127:0] den,
                                      output longint q_out);
        logic signed [191:0] n, dv, qt, rm;
        n = 192'(num) <<< wsi_pkg::FRAC_BITS;
        dv = 192'(den);
        qt = n / dv;
        rm = n - qt * dv;
        if (rm != 0 && ((rm < 0) != (dv < 0))) qt = qt - 1;
        q_out = 0;
        if (qt > 192'sh7FFFFFFFFFFFFFFF || qt < -192'sh8000000000000000) return 1'b0;
        q_out = longint'(qt);
        if (q_out < low_lim || q_out > high_lim) return 1'b0;
        if (q_out == high_lim && rm != 0) return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic signed [31:0] sat32(logic signed [127:0] v);
        if (v > 128'sh7FFFFFFF) return 32'sh7FFFFFFF;
        if (v < -128'sh80000000) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic crossing_t solve_crossing(seg_pair_t s);
        crossing_t r;
        longint lat, lon, nlat, nlon, alat, alon, blat, blon;
        longint dx1, dx2, dym, dyb, x, y, t, ts;
        logic signed [127:0] det, prod;
        r = '{1'b0, '0, '0, '0};
        lat = s.c[0]; lon = s.c[1]; nlat = s.c[2]; nlon = s.c[3];
        alat = s.c[4]; alon = s.c[5]; blat = s.c[6]; blon = s.c[7];
        if (lon < 0) lon += TWO_PI_V;
        if (nlon < 0) nlon += TWO_PI_V;
        if (alon < 0) alon += TWO_PI_V;
        if (blon < 0) blon += TWO_PI_V;
        if ((lon > nlon ? lon - nlon : nlon - lon) > PI_V)
        begin
            if (lon > nlon) lon -= TWO_PI_V; else nlon -= TWO_PI_V;
        end
        if ((alon > blon ? alon - blon : blon - alon) > PI_V)
        begin
            if (alon > blon) alon -= TWO_PI_V; else blon -= TWO_PI_V;
        end
        if ((lon > alon ? lon - alon : alon - lon) > PI_V)
        begin
            if (lon > alon)
            begin
                lon -= TWO_PI_V;
                nlon -= TWO_PI_V;
            end
            else
            begin
                alon -= TWO_PI_V;
                blon -= TWO_PI_V;
            end
        end
        dx1 = nlon - lon; dx2 = blon - alon;
        dym = nlat - lat; dyb = blat - alat;
        x = lon - alon; y = lat - alat;
        det = 128'(dyb) * 128'(dx1) - 128'(dx2) * 128'(dym);
        if (det == 0) return r;
        if (!ratio_ok(128'(dx2) * 128'(y) - 128'(dyb) * 128'(x), det, t)) return r;
        if (!ratio_ok(128'(dx1) * 128'(y) - 128'(dym) * 128'(x), det, ts)) return r;
        r.hit = 1'b1;
        r.ratio = t[31:0];
        prod = 128'(t) * 128'(dym);
        r.lat = sat32(128'(lat) + (prod >>> wsi_pkg::FRAC_BITS));
        prod = 128'(t) * 128'(dx1);
        r.lon = sat32(128'(lon) + (prod >>> wsi_pkg::FRAC_BITS));
        return r;
    endfunction

    task automatic report_mismatch(string what, logic signed [31:0] got, logic signed [31:0] want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // Results cannot be held off, so every beat is captured on the edge that ends it.
    always @(posedge clk)
    begin
        crossing_t want;
        if (rst_n && done)
        begin
            beats_seen++;
            if (crossing_q.size() == 0)
            begin
                $display("[%0t] result beat with nothing expected", $realtime);
                errors++;
            end
            else
            begin
                want = crossing_q.pop_front();
                if (hit) hits_seen++;
                if (hit !== want.hit) report_mismatch("hit", 32'(hit), 32'(want.hit));
                if (move_ratio !== want.ratio) report_mismatch("move_ratio", move_ratio, want.ratio);
                if (cross_lat !== want.lat) report_mismatch("cross_lat", cross_lat, want.lat);
                if (cross_lon !== want.lon) report_mismatch("cross_lon", cross_lon, want.lon);
            end
        end
    end

    task automatic write_limit(wsi_pkg::reg_idx_t idx, longint val);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 3'(int'(idx) * 4); pwdata <= 32'(val);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == wsi_pkg::REG_LOW) low_lim = val; else high_lim = val;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (crossing_q.size() != 0 && guard < 10_000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // Drives one item; start stays high across back-to-back beats.
    task automatic send_item(seg_pair_t s, logic typed, crossing_t typed_res);
        crossing_t pred;
        while ($urandom_range(99) < send_gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        for (int i = 0; i < 8; i++) coord[i] <= s.c[i];
        start <= 1'b1;
        do @(posedge clk); while (busy);
        pred = solve_crossing(s);
        if (typed && pred != typed_res)
        begin
            $display("[%0t] directed row disagrees with the prediction", $realtime);
            errors++;
        end
        crossing_q.push_back(typed ? typed_res : pred);
    endtask

    function automatic logic signed [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(2 * 843314857)) - 843314857);
            default: return 32'($signed($urandom_range(2000)) - 1000) <<< 18;
        endcase
    endfunction

    // A move that is built to cross a barrier, so that hits are common.
    function automatic seg_pair_t crossing_pair();
        seg_pair_t s;
        int mode;
        longint px, py;
        mode = $urandom_range(2);
        px = $signed($urandom_range(1_600_000_000)) - 100_000_000;
        py = $signed($urandom_range(800_000_000)) - 400_000_000;
        for (int i = 0; i < 8; i++) s.c[i] = rand_coord(mode);
        s.c[0] = 32'(py - $urandom_range(60_000_000));
        s.c[1] = 32'(px - $urandom_range(60_000_000));
        s.c[2] = 32'(2 * py - s.c[0]);
        s.c[3] = 32'(2 * px - s.c[1]);
        s.c[4] = 32'(py + $urandom_range(60_000_000));
        s.c[5] = 32'(px - $urandom_range(60_000_000));
        s.c[6] = 32'(2 * py - s.c[4]);
        s.c[7] = 32'(2 * px - s.c[5]);
        return s;
    endfunction

    table_row_t dir_rows [$];
    crossing_t miss = '{1'b0, '0, '0, '0};

    function automatic table_row_t row(longint a, longint b, longint c, longint d,
                                       longint e, longint f, longint g, longint h,
                                       logic typed, crossing_t res);
        table_row_t r;
        r.c[0] = 32'(a); r.c[1] = 32'(b); r.c[2] = 32'(c); r.c[3] = 32'(d);
        r.c[4] = 32'(e); r.c[5] = 32'(f); r.c[6] = 32'(g); r.c[7] = 32'(h);
        r.typed = typed; r.res = res;
        return r;
    endfunction

    initial
    begin
        seg_pair_t s;
        longint lo_set [4] = '{0, -536870912, -268435456, 536870912};
        longint hi_set [4] = '{536870912, 268435456, 536870912, -536870912};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero-length, parallel and out-of-reach pairs miss; a centred cross hits at ratio one half.
        dir_rows.push_back(row(0, 0, 0, 0, 0, 0, 0, 0, 1, miss));
        dir_rows.push_back(row(0, 0, 0, ONE_Q, ONE_Q, 0, ONE_Q, ONE_Q, 1, miss));
        dir_rows.push_back(row(-ONE_Q, 0, ONE_Q, 0, 0, -ONE_Q/2, 0, ONE_Q/2, 0, miss));
        dir_rows.push_back(row(0, 0, ONE_Q, ONE_Q, ONE_Q, 0, 0, ONE_Q, 1,
                               '{1'b1, 32'(ONE_Q/2), 32'(ONE_Q/2), 32'(ONE_Q/2)}));
        dir_rows.push_back(row(0, 0, 0, ONE_Q, ONE_Q, 2*ONE_Q, -ONE_Q, 2*ONE_Q, 1, miss));
        dir_rows.push_back(row(-2147483648, -2147483648, 2147483647, 2147483647,
                               2147483647, -2147483648, -2147483648, 2147483647, 0, miss));
        dir_rows.push_back(row(2147483647, 2147483647, -2147483648, -2147483648,
                               -2147483648, 2147483647, 2147483647, -2147483648, 0, miss));
        // Crossing the zero meridian, and pairs split around it.
        dir_rows.push_back(row(0, -ONE_Q/8, 0, ONE_Q/8, -ONE_Q/8, 0, ONE_Q/8, 0, 0, miss));
        dir_rows.push_back(row(ONE_Q/8, -1, -ONE_Q/8, 1, 0, 2*ONE_Q, 0, -2*ONE_Q, 0, miss));
        dir_rows.push_back(row(0, TWO_PI_V - 1000, 0, 1000, -500, 0, 500, 0, 0, miss));
        dir_rows.push_back(row(0, 3*ONE_Q, 0, -3*ONE_Q, -ONE_Q, PI_V, ONE_Q, PI_V, 0, miss));
        dir_rows.push_back(row(0, 1, 0, -1, -1, 0, 1, 0, 0, miss));
        // End points exactly on the limits, and a ratio just beyond one.
        dir_rows.push_back(row(0, 0, 0, ONE_Q, -ONE_Q, ONE_Q, ONE_Q, ONE_Q, 0, miss));
        dir_rows.push_back(row(0, 0, 0, ONE_Q, -ONE_Q, 0, ONE_Q, 0, 0, miss));
        dir_rows.push_back(row(0, 0, 0, 3, -ONE_Q, 4, ONE_Q, 4, 0, miss));
        dir_rows.push_back(row(0, 0, 0, 3, -ONE_Q, 2, ONE_Q, 2, 0, miss));

        foreach (dir_rows[i])
        begin
            for (int k = 0; k < 8; k++) s.c[k] = dir_rows[i].c[k];
            send_item(s, dir_rows[i].typed, dir_rows[i].res);
        end
        start <= 1'b0;
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph < 4)
            begin
                write_limit(wsi_pkg::REG_LOW, lo_set[ph]);
                write_limit(wsi_pkg::REG_HIGH, hi_set[ph]);
            end
            else
            begin
                write_limit(wsi_pkg::REG_LOW, ph == 4 ? 0 : -536870912);
                write_limit(wsi_pkg::REG_HIGH, ph == 4 ? ONE_Q : 536870912);
            end
            send_gap_pct = (ph < 2) ? 25 : (ph < 4 ? 55 : 0);
            for (int n = 0; n < 250; n++)
            begin
                if ($urandom_range(99) < 70)
                    s = crossing_pair();
                else
                    for (int k = 0; k < 8; k++) s.c[k] = rand_coord($urandom_range(2));
                if (n == 120)
                begin
                    start <= 1'b0;
                    while (crossing_q.size() != 0) @(posedge clk);
                end
                send_item(s, 1'b0, miss);
            end
            start <= 1'b0;
            drain();
        end

        $display("Covered %0d result beats, %0d of them hits, over six limit settings.",
                 beats_seen, hits_seen);
        if (errors == 0 && crossing_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
